// ----- hw/rtl/gcpf_pkg.sv -----
// Package for the GPU command packet framer: packet length table, polyline
// terminator constants and the result record type. No dependencies.
`default_nettype none

package gcpf_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    // Output tdata: packet_word, command_code, word_index
    localparam int unsigned OUT_W   = WORD_W + 2 * BYTE_W;

    localparam logic [WORD_W-1:0] POLY_MASK  = 32'hF000_F000;
    localparam logic [WORD_W-1:0] POLY_TERM  = 32'h5000_5000;
    localparam logic [BYTE_W-1:0] LEN_FLAT   = 8'd254;
    localparam logic [BYTE_W-1:0] LEN_SHADED = 8'd255;
    localparam logic [BYTE_W-1:0] LEN_LONG   = 8'd128;
    localparam logic [BYTE_W-1:0] FLAT_START   = 8'd3;
    localparam logic [BYTE_W-1:0] SHADED_START = 8'd4;

    // Packet length in words for each opcode, zero for an unknown opcode
    localparam logic [BYTE_W-1:0] LEN_TABLE [256] = '{
        8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd7, 8'd7, 8'd7, 8'd7,
        8'd5, 8'd5, 8'd5, 8'd5, 8'd9, 8'd9, 8'd9, 8'd9,
        8'd6, 8'd6, 8'd6, 8'd6, 8'd9, 8'd9, 8'd9, 8'd9,
        8'd8, 8'd8, 8'd8, 8'd8, 8'd12, 8'd12, 8'd12, 8'd12,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // One framed word on its way out
    typedef struct packed {
        logic              packet_end;
        logic [BYTE_W-1:0] word_index;
        logic [BYTE_W-1:0] command_code;
        logic [WORD_W-1:0] packet_word;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gpu_command_packet_framer.sv -----
// Top level of the GPU command packet framer: frames command-port words into
// packets using the opcode length table. Depends on gcpf_pkg.
// A framed word is registered in the output entry, or in the skid entry while
// the output is stalled. Throughput: one word per cycle while the skid entry is
// empty; the frame state update (table read, position increment, terminator
// compare) is the only loop. A two-entry output register and skid stage keep
// the slave side open while one result waits to be taken.
// Reset (rst_n low, asynchronous): framer idle, both output entries empty.
`default_nettype none

module gpu_command_packet_framer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] port_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [gcpf_pkg::OUT_W-1:0] m_tdata, // [31:0] packet_word,
                                                // [39:32] command_code,
                                                // [47:40] word_index
    output logic             m_tlast    // packet_end
);

    // Frame state
    logic [7:0] expected_reg, expected_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] command_reg,  command_next;

    // Output entry and skid entry
    logic                out_valid_reg, out_valid_next;
    gcpf_pkg::result_t   out_reg,       out_next;
    logic                skid_valid_reg, skid_valid_next;
    gcpf_pkg::result_t   skid_reg,       skid_next;

    logic              in_fire;
    logic              out_fire;
    logic              idle;
    logic [7:0]        opcode;
    logic [7:0]        table_len;
    logic              has_result;
    logic              armed;
    logic              term_hit;
    logic [7:0]        run_len;
    logic [7:0]        next_pos;
    gcpf_pkg::result_t res;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Frame the incoming word against the current packet state
    always_comb
    begin
        idle      = (expected_reg == 8'd0);
        opcode    = s_tdata[31:24];
        table_len = gcpf_pkg::LEN_TABLE[opcode];
        armed     = ((expected_reg == gcpf_pkg::LEN_FLAT) &&
                     (position_reg >= gcpf_pkg::FLAT_START)) ||
                    ((expected_reg == gcpf_pkg::LEN_SHADED) &&
                     (position_reg >= gcpf_pkg::SHADED_START) && !position_reg[0]);
        term_hit  = (expected_reg > gcpf_pkg::LEN_LONG) && armed &&
                    ((s_tdata & gcpf_pkg::POLY_MASK) == gcpf_pkg::POLY_TERM);

        res.packet_word = s_tdata;
        if (idle)
        begin
            has_result       = (table_len != 8'd0);
            run_len          = table_len;
            next_pos         = 8'd1;
            res.command_code = opcode;
            res.word_index   = 8'd0;
        end
        else
        begin
            has_result       = 1'b1;
            run_len          = expected_reg;
            next_pos         = term_hit ? expected_reg : position_reg + 8'd1;
            res.command_code = command_reg;
            res.word_index   = position_reg;
        end
        res.packet_end = (next_pos == run_len);
    end

    // Advance the frame state on each accepted word that joins a packet
    always_comb
    begin
        expected_next = expected_reg;
        position_next = position_reg;
        command_next  = command_reg;
        if (in_fire && has_result)
        begin
            command_next = res.command_code;
            if (res.packet_end)
            begin
                expected_next = 8'd0;
                position_next = 8'd0;
            end
            else
            begin
                expected_next = run_len;
                position_next = next_pos;
            end
        end
    end

    // Fill the output entry first, park in the skid entry when it is stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire && has_result;
                out_next       = res;
            end
        end
        else if (in_fire && has_result)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= 8'd0;
            position_reg   <= 8'd0;
            command_reg    <= 8'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg   <= expected_next;
            position_reg   <= position_next;
            command_reg    <= command_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.word_index, out_reg.command_code, out_reg.packet_word};
    assign m_tlast  = out_reg.packet_end;

endmodule

`default_nettype wire

// ----- hw/rtl/gcpf_checker.sv -----
// Port-level checker for the GPU command packet framer, bound to the top level.
// Depends on gcpf_pkg and gpu_command_packet_framer.
`default_nettype none

module gcpf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);

    // Stalled transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // Slave side closes only when both output entries are full
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("slave side stalled with empty output");

    // Opcode word carries its own top byte as command code
    a_opword: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[47:40] == 8'd0) |-> (m_tdata[39:32] == m_tdata[31:24]))
        else $error("opcode word command code mismatch");

    // Word index stays within the longest packet and the command code is a known opcode
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:40] != 8'hFF) &&
                     (gcpf_pkg::LEN_TABLE[m_tdata[39:32]] != 8'd0))
        else $error("word index or command code out of range");

endmodule

bind gpu_command_packet_framer gcpf_checker u_gcpf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
